### rtl/pci_config_scan_sequencer_defines.svh
// Assertion macros for the PCI config scan sequencer.
// Used by modules that include this header; expects clk_i and rst_ni in scope.
`ifndef PCI_CONFIG_SCAN_SEQUENCER_DEFINES_SVH
`define PCI_CONFIG_SCAN_SEQUENCER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define PCSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define PCSS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/pcss_pkg.sv
// Shared types, codes and helpers of the PCI config scan sequencer.
// No dependencies; used by pcss_core and pci_config_scan_sequencer.
`timescale 1ns / 1ps

package pcss_pkg;

  // input item kinds (tuser of the slave side)
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_REPLY = 2'd2;

  // result item kinds (tuser of the master side)
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_RECORD  = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // config space byte offsets
  localparam logic [7:0] OFS_IDENT  = 8'h00;
  localparam logic [7:0] OFS_CLASS  = 8'h08;
  localparam logic [7:0] OFS_HEADER = 8'h0E;

  localparam logic [31:0] CFG_ENABLE    = 32'h8000_0000;
  localparam logic [7:0]  DWORD_MASK    = 8'hFC;
  localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
  localparam int unsigned MULTI_FN_BIT  = 7;

  localparam logic [7:0] BUS_LAST = 8'd255;
  localparam logic [4:0] DEV_LAST = 5'd31;
  localparam logic [2:0] FN_LAST  = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] read_data;
    logic        keep_going;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cfg_address;
    logic [7:0]  bus_number;
    logic [4:0]  device_number;
    logic [2:0]  function_number;
    logic [15:0] vendor;
    logic [15:0] device_ident;
    logic [7:0]  revision;
    logic [7:0]  programming_interface;
    logic [7:0]  sub_class;
    logic [7:0]  base_class;
    logic [7:0]  header_kind;
  } result_t;

  // mechanism-1 address word
  function automatic logic [31:0] cfg_addr(input logic [7:0] bus, input logic [4:0] dev,
                                           input logic [2:0] fn, input logic [7:0] ofs);
    cfg_addr = CFG_ENABLE | {8'h00, bus, dev, fn, ofs & DWORD_MASK};
  endfunction

endpackage

### rtl/pcss_core.sv
// Scan state machine of the PCI config scan sequencer: slot walk and record build.
// Depends on pcss_pkg and pci_config_scan_sequencer_defines.svh.
`timescale 1ns / 1ps
`include "pci_config_scan_sequencer_defines.svh"

module pcss_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  pcss_pkg::item_t   item_i,
  input  logic              scan_enable_i,
  output logic              res_valid_o,
  output pcss_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_IDENT,
    PH_CLASS,
    PH_HEADER,
    PH_VISIT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  cur_bus_q, cur_bus_d;
  logic [4:0]  cur_dev_q, cur_dev_d;
  logic [2:0]  cur_fn_q, cur_fn_d;
  logic        multi_fn_q, multi_fn_d;
  logic [31:0] ident_word_q, ident_word_d;
  logic [31:0] class_word_q, class_word_d;

  // next slot of the walk
  logic [7:0] nxt_bus;
  logic [4:0] nxt_dev;
  logic [2:0] nxt_fn;
  logic       nxt_multi;
  logic       nxt_more;
  logic [7:0] header;

  always_comb begin
    nxt_bus   = cur_bus_q;
    nxt_dev   = cur_dev_q;
    nxt_fn    = 3'd0;
    nxt_multi = 1'b0;
    nxt_more  = 1'b1;
    if (multi_fn_q && (cur_fn_q != pcss_pkg::FN_LAST)) begin
      nxt_fn    = cur_fn_q + 3'd1;
      nxt_multi = 1'b1;
    end else if (cur_dev_q != pcss_pkg::DEV_LAST) begin
      nxt_dev = cur_dev_q + 5'd1;
    end else begin
      nxt_dev = 5'd0;
      if (cur_bus_q != pcss_pkg::BUS_LAST) begin
        nxt_bus = cur_bus_q + 8'd1;
      end else begin
        nxt_bus  = 8'd0;
        nxt_more = 1'b0;
      end
    end
  end

  assign header = item_i.read_data[23:16];

  always_comb begin
    phase_d      = phase_q;
    cur_bus_d    = cur_bus_q;
    cur_dev_d    = cur_dev_q;
    cur_fn_d     = cur_fn_q;
    multi_fn_d   = multi_fn_q;
    ident_word_d = ident_word_q;
    class_word_d = class_word_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (phase_q)
      PH_IDLE: begin
        if (item_i.func == pcss_pkg::FUNC_START) begin
          res_valid_o = 1'b1;
          if (!scan_enable_i) begin
            res_o.kind = pcss_pkg::KIND_DONE;
          end else begin
            cur_bus_d         = 8'd0;
            cur_dev_d         = 5'd0;
            cur_fn_d          = 3'd0;
            multi_fn_d        = 1'b0;
            res_o.kind        = pcss_pkg::KIND_REQUEST;
            res_o.cfg_address = pcss_pkg::cfg_addr(8'd0, 5'd0, 3'd0, pcss_pkg::OFS_IDENT);
            phase_d           = PH_IDENT;
          end
        end
      end
      PH_IDENT: begin
        if (item_i.func == pcss_pkg::FUNC_READ) begin
          res_valid_o  = 1'b1;
          ident_word_d = item_i.read_data;
          if (item_i.read_data[15:0] == pcss_pkg::VENDOR_ABSENT) begin
            // absent slot: move on
            cur_bus_d  = nxt_bus;
            cur_dev_d  = nxt_dev;
            cur_fn_d   = nxt_fn;
            multi_fn_d = nxt_multi;
            if (nxt_more) begin
              res_o.kind            = pcss_pkg::KIND_REQUEST;
              res_o.cfg_address     = pcss_pkg::cfg_addr(nxt_bus, nxt_dev, nxt_fn,
                                                         pcss_pkg::OFS_IDENT);
              res_o.bus_number      = nxt_bus;
              res_o.device_number   = nxt_dev;
              res_o.function_number = nxt_fn;
              phase_d               = PH_IDENT;
            end else begin
              res_o.kind = pcss_pkg::KIND_DONE;
              phase_d    = PH_IDLE;
            end
          end else begin
            res_o.kind            = pcss_pkg::KIND_REQUEST;
            res_o.cfg_address     = pcss_pkg::cfg_addr(cur_bus_q, cur_dev_q, cur_fn_q,
                                                       pcss_pkg::OFS_CLASS);
            res_o.bus_number      = cur_bus_q;
            res_o.device_number   = cur_dev_q;
            res_o.function_number = cur_fn_q;
            phase_d               = PH_CLASS;
          end
        end
      end
      PH_CLASS: begin
        if (item_i.func == pcss_pkg::FUNC_READ) begin
          res_valid_o           = 1'b1;
          class_word_d          = item_i.read_data;
          res_o.kind            = pcss_pkg::KIND_REQUEST;
          res_o.cfg_address     = pcss_pkg::cfg_addr(cur_bus_q, cur_dev_q, cur_fn_q,
                                                     pcss_pkg::OFS_HEADER);
          res_o.bus_number      = cur_bus_q;
          res_o.device_number   = cur_dev_q;
          res_o.function_number = cur_fn_q;
          phase_d               = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (item_i.func == pcss_pkg::FUNC_READ) begin
          res_valid_o = 1'b1;
          // only function 0 decides multi-function
          if (cur_fn_q == 3'd0) begin
            multi_fn_d = header[pcss_pkg::MULTI_FN_BIT];
          end
          res_o.kind                  = pcss_pkg::KIND_RECORD;
          res_o.bus_number            = cur_bus_q;
          res_o.device_number         = cur_dev_q;
          res_o.function_number       = cur_fn_q;
          res_o.vendor                = ident_word_q[15:0];
          res_o.device_ident          = ident_word_q[31:16];
          res_o.revision              = class_word_q[7:0];
          res_o.programming_interface = class_word_q[15:8];
          res_o.sub_class             = class_word_q[23:16];
          res_o.base_class            = class_word_q[31:24];
          res_o.header_kind           = header;
          phase_d                     = PH_VISIT;
        end
      end
      PH_VISIT: begin
        if (item_i.func == pcss_pkg::FUNC_REPLY) begin
          res_valid_o = 1'b1;
          if (!item_i.keep_going) begin
            res_o.kind = pcss_pkg::KIND_DONE;
            phase_d    = PH_IDLE;
          end else begin
            cur_bus_d  = nxt_bus;
            cur_dev_d  = nxt_dev;
            cur_fn_d   = nxt_fn;
            multi_fn_d = nxt_multi;
            if (nxt_more) begin
              res_o.kind            = pcss_pkg::KIND_REQUEST;
              res_o.cfg_address     = pcss_pkg::cfg_addr(nxt_bus, nxt_dev, nxt_fn,
                                                         pcss_pkg::OFS_IDENT);
              res_o.bus_number      = nxt_bus;
              res_o.device_number   = nxt_dev;
              res_o.function_number = nxt_fn;
              phase_d               = PH_IDENT;
            end else begin
              res_o.kind = pcss_pkg::KIND_DONE;
              phase_d    = PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cur_bus_q  <= 8'd0;
      cur_dev_q  <= 5'd0;
      cur_fn_q   <= 3'd0;
      multi_fn_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      cur_bus_q  <= cur_bus_d;
      cur_dev_q  <= cur_dev_d;
      cur_fn_q   <= cur_fn_d;
      multi_fn_q <= multi_fn_d;
    end
  end

  // payload words, no reset
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      ident_word_q <= ident_word_d;
      class_word_q <= class_word_d;
    end
  end

  `PCSS_ASSERT(a_record_only_from_header, res_valid_o && (res_o.kind == pcss_pkg::KIND_RECORD) |-> phase_q == PH_HEADER, "record built outside header phase")
  `PCSS_ASSERT(a_request_addr_matches_slot, res_valid_o && (res_o.kind == pcss_pkg::KIND_REQUEST) |-> res_o.cfg_address[31] && (res_o.cfg_address[23:16] == res_o.bus_number) && (res_o.cfg_address[10:8] == res_o.function_number), "request address does not match slot")
  `PCSS_ASSERT_NEXT(a_reply_leaves_visit, step_i && (phase_q == PH_VISIT) && (item_i.func == pcss_pkg::FUNC_REPLY), (phase_q == PH_IDLE) || (phase_q == PH_IDENT), "reply did not leave visit phase")
  `PCSS_ASSERT_NEXT(a_start_from_slot_zero, step_i && (phase_q == PH_IDLE) && (item_i.func == pcss_pkg::FUNC_START) && scan_enable_i, (phase_q == PH_IDENT) && (cur_bus_q == 8'd0) && (cur_dev_q == 5'd0) && (cur_fn_q == 3'd0), "scan did not start at slot zero")

endmodule

### rtl/pci_config_scan_sequencer.sv
// PCI config scan sequencer (configuration mechanism 1 bus enumeration), top level.
// Instantiates pcss_core; depends on pcss_pkg.
//
// Usage:
//  - cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes scan_enable; always ready.
//    Write it only while no scan runs. It is sampled when a start item is taken.
//  - Slave stream: tuser = func (0 start, 1 read data, 2 visitor reply); tdata carries
//    the read dword and the keep_going flag. Items that do not fit the current phase
//    are dropped without a result.
//  - Master stream: tuser = kind (0 config read request, 1 device record, 2 done);
//    tdata carries the address word, slot numbers and record fields.
//  - Each present function costs three read requests (offsets 0x00, 0x08, 0x0E as a
//    dword at 0x0C), then one record; a reply item resumes the scan if keep_going is set.
// Timing: one item per cycle sustained while m_axis_tready is high. An item is held in
// the input register and its result is loaded into the output register at the next edge
// on which it advances, so tvalid and the result are registered.
// The input register and the output register let one more item in while a
// result waits on a stalled receiver; after that s_axis_tready drops until
// m_axis_tready returns.
// Reset: asynchronous, active low; scan idle at slot 0, scan_enable cleared, both
// stream registers empty.
`timescale 1ns / 1ps

module pci_config_scan_sequencer (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,      // scan_enable
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,    // read_data[31:0], keep_going[32], zero[39:33]
  input  logic [1:0]   s_axis_tuser,    // func[1:0]
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,    // cfg_address[31:0], bus_number[39:32],
                                        // device_number[44:40], function_number[47:45],
                                        // vendor[63:48], device_ident[79:64],
                                        // revision[87:80], programming_interface[95:88],
                                        // sub_class[103:96], base_class[111:104],
                                        // header_kind[119:112]
  output logic [1:0]   m_axis_tuser     // kind[1:0]
);

  logic              scan_enable_q;
  logic              in_valid_q;
  pcss_pkg::item_t   in_item_q;
  logic              out_valid_q;
  pcss_pkg::result_t out_q;

  logic              advance;   // output register can take a new value
  logic              step;      // item in the input register is processed
  logic              res_valid;
  pcss_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      scan_enable_q <= cfg_data_i;
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.func       <= s_axis_tuser;
      in_item_q.read_data  <= s_axis_tdata[31:0];
      in_item_q.keep_going <= s_axis_tdata[32];
    end
  end

  pcss_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (in_item_q),
    .scan_enable_i (scan_enable_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // result register; items without a result leave it empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {out_q.header_kind, out_q.base_class, out_q.sub_class,
                          out_q.programming_interface, out_q.revision,
                          out_q.device_ident, out_q.vendor, out_q.function_number,
                          out_q.device_number, out_q.bus_number, out_q.cfg_address};

endmodule
